>>> hw/rtl/modbus_rtu_response_checker_defines.svh
// ----------------------------------------------------------------------------
// Modbus RTU response checker assertion macros
// Shared macros for the concurrent checks in the response checker RTL.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modbus_rtu_response_checker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modbus_rtu_response_checker: next-cycle check failed");

`endif

>>> hw/rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Types, codes and helper functions shared by the response checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

    localparam int unsigned MAX_FRAME_BYTES_VAL = 256;
    localparam int unsigned POS_W = 9;

    localparam logic [POS_W-1:0] MAX_FRAME_BYTES = POS_W'(MAX_FRAME_BYTES_VAL);
    localparam logic [POS_W-1:0] POS_CAP = {POS_W{1'b1}};

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [8:0]  EXC_FLAG = 9'h080;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQ_FUNCTION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQ_QUANTITY = 1'b1;

    localparam logic [7:0]  REQ_FUNCTION_RESET = 8'd3;
    localparam logic [15:0] REQ_QUANTITY_RESET = 16'd0;

    localparam logic [7:0] FN_READ_COILS      = 8'd1;
    localparam logic [7:0] FN_READ_DISCRETE   = 8'd2;
    localparam logic [7:0] FN_READ_HOLDING    = 8'd3;
    localparam logic [7:0] FN_READ_INPUT      = 8'd4;
    localparam logic [7:0] FN_READ_EXC_STATUS = 8'd7;
    localparam logic [7:0] FN_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FN_WRITE_REGS      = 8'd16;
    localparam logic [7:0] FN_REPORT_ID       = 8'd17;
    localparam logic [7:0] FN_READ_WRITE_REGS = 8'd23;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        FS_OK        = 3'd0,
        FS_LENGTH    = 3'd1,
        FS_FUNCTION  = 3'd2,
        FS_COUNT     = 3'd3,
        FS_EXCEPTION = 3'd4
    } t_frame_status;

    typedef struct packed {
        logic [7:0]  seen_function;
        logic [7:0]  seen_byte_count;
        logic [15:0] seen_write_quantity;
        logic [9:0]  frame_len;
        logic        overrun;
    } t_frame_info;

    typedef struct packed {
        t_frame_status status;
        logic [15:0]   value_count;
        logic [7:0]    exc_code;
    } t_verdict;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] data_word;
        logic [6:0]  word_index;
        logic [2:0]  frame_status;
        logic [15:0] value_count;
        logic        crc_match;
        logic [7:0]  exc_code;
    } t_result;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic is_register_read(input logic [7:0] fn);
        return (fn == FN_READ_HOLDING) || (fn == FN_READ_INPUT) ||
               (fn == FN_READ_WRITE_REGS);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mrc_status_eval.sv
// ----------------------------------------------------------------------------
// Modbus RTU response status evaluation
// Judges a finished frame against the request's function code and quantity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrc_status_eval (
    input  wire logic [7:0]         i_req_function,
    input  wire logic [15:0]        i_req_quantity,
    input  wire mrc_pkg::t_frame_info i_info,
    output mrc_pkg::t_verdict       o_verdict
);

    logic [13:0] coil_bytes;
    logic [16:0] coil_sum;
    logic [17:0] expect_len;
    logic        any_len;
    logic        len_fit;
    logic        is_exception;
    logic [15:0] want;
    logic [15:0] got;

    assign coil_sum   = {1'b0, i_req_quantity} + 17'd7;
    assign coil_bytes = coil_sum[16:3];

    always_comb begin
        expect_len = 18'd8;
        any_len    = 1'b0;
        want       = 16'd1;
        got        = 16'd1;
        unique case (i_req_function) inside
            mrc_pkg::FN_READ_COILS, mrc_pkg::FN_READ_DISCRETE: begin
                expect_len = {4'b0, coil_bytes} + 18'd5;
                want       = {2'b0, coil_bytes};
                got        = {8'b0, i_info.seen_byte_count};
            end
            mrc_pkg::FN_READ_HOLDING, mrc_pkg::FN_READ_INPUT,
            mrc_pkg::FN_READ_WRITE_REGS: begin
                expect_len = {1'b0, i_req_quantity, 1'b0} + 18'd5;
                want       = i_req_quantity;
                got        = {9'b0, i_info.seen_byte_count[7:1]};
            end
            mrc_pkg::FN_READ_EXC_STATUS: begin
                expect_len = 18'd6;
            end
            mrc_pkg::FN_WRITE_COILS, mrc_pkg::FN_WRITE_REGS: begin
                want = i_req_quantity;
                got  = i_info.seen_write_quantity;
            end
            mrc_pkg::FN_REPORT_ID: begin
                any_len = 1'b1;
                want    = {8'b0, i_info.seen_byte_count};
                got     = {8'b0, i_info.seen_byte_count};
            end
            default: begin
                expect_len = 18'd8;
            end
        endcase
    end

    assign len_fit = !i_info.overrun &&
                     (any_len || ({8'b0, i_info.frame_len} == expect_len));

    assign is_exception = !i_info.overrun && (i_info.frame_len == 10'd5) &&
                          ({1'b0, i_info.seen_function} ==
                           ({1'b0, i_req_function} + mrc_pkg::EXC_FLAG));

    always_comb begin
        o_verdict.status      = mrc_pkg::FS_LENGTH;
        o_verdict.value_count = 16'd0;
        o_verdict.exc_code    = 8'd0;
        if (len_fit) begin
            if (i_info.seen_function != i_req_function) begin
                o_verdict.status = mrc_pkg::FS_FUNCTION;
            end else if (want == got) begin
                o_verdict.status      = mrc_pkg::FS_OK;
                o_verdict.value_count = got;
            end else begin
                o_verdict.status = mrc_pkg::FS_COUNT;
            end
        end else if (is_exception) begin
            o_verdict.status   = mrc_pkg::FS_EXCEPTION;
            o_verdict.exc_code = i_info.seen_byte_count;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/modbus_rtu_response_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker: one byte per cycle while o_stall is low; results are registered.
// CRC, field capture and status are one registered pass; output has a skid slot.
// Synchronous reset clears frame state, output valids, function 3, quantity 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_rtu_response_checker_defines.svh"

module modbus_rtu_response_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_result_kind,
    output logic [15:0]      o_data_word,
    output logic [6:0]       o_word_index,
    output logic [2:0]       o_frame_status,
    output logic [15:0]      o_value_count,
    output logic             o_crc_match,
    output logic [7:0]       o_exc_code
);

    logic [7:0]  r_req_function;
    logic [15:0] r_req_quantity;

    logic [15:0] r_crc, n_crc;
    logic [8:0]  r_pos, n_pos;
    logic [7:0]  r_dly0, n_dly0;
    logic [7:0]  r_dly1, n_dly1;
    logic [7:0]  r_seen_func, n_seen_func;
    logic [7:0]  r_seen_cnt, n_seen_cnt;
    logic [15:0] r_seen_wq, n_seen_wq;
    logic [7:0]  r_word_hi, n_word_hi;
    logic        r_overrun, n_overrun;

    logic            r_out_valid, n_out_valid;
    logic            r_skid_valid, n_skid_valid;
    mrc_pkg::t_result r_out, n_out;
    mrc_pkg::t_result r_skid, n_skid;

    logic             in_acc;
    logic             out_free;
    logic [15:0]      crc_fed;
    logic             overrun_now;
    logic [7:0]       seen_func_now;
    logic [7:0]       seen_cnt_now;
    logic [15:0]      seen_wq_now;
    logic             hi_slot;
    logic             word_slot;
    logic [7:0]       word_idx;
    logic             emit_word;
    logic             has_res;
    logic             crc_ok;
    logic             frame_cleared;
    logic             data_out;
    logic             data_fields_clear;
    mrc_pkg::t_frame_info info;
    mrc_pkg::t_verdict    verdict;
    mrc_pkg::t_result     res;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign crc_fed = (r_pos >= 9'd2) ? mrc_pkg::crc16_update(r_crc, r_dly1) : r_crc;
    assign overrun_now = r_overrun || (r_pos == mrc_pkg::MAX_FRAME_BYTES);

    assign seen_func_now = (r_pos == 9'd1) ? i_rx_byte : r_seen_func;
    assign seen_cnt_now  = (r_pos == 9'd2) ? i_rx_byte : r_seen_cnt;
    assign seen_wq_now   = (r_pos == 9'd4) ? {i_rx_byte, r_seen_wq[7:0]} :
                           (r_pos == 9'd5) ? {r_seen_wq[15:8], i_rx_byte} : r_seen_wq;

    assign hi_slot   = (r_pos >= 9'd3) && r_pos[0];
    assign word_slot = (r_pos >= 9'd4) && !r_pos[0];
    assign word_idx  = r_pos[8:1] - 8'd2;
    assign emit_word = word_slot && mrc_pkg::is_register_read(r_req_function) &&
                       ({8'b0, word_idx} < r_req_quantity) && !word_idx[7];

    assign info.seen_function       = seen_func_now;
    assign info.seen_byte_count     = seen_cnt_now;
    assign info.seen_write_quantity = seen_wq_now;
    assign info.frame_len           = {1'b0, r_pos} + 10'd1;
    assign info.overrun             = overrun_now;

    mrc_status_eval u_status_eval (
        .i_req_function (r_req_function),
        .i_req_quantity (r_req_quantity),
        .i_info         (info),
        .o_verdict      (verdict)
    );

    assign crc_ok  = (r_pos != 9'd0) &&
                     ({r_dly0, i_rx_byte} == {crc_fed[7:0], crc_fed[15:8]});
    assign has_res = i_frame_end || emit_word;

    always_comb begin
        if (i_frame_end) begin
            res.result_kind  = mrc_pkg::KIND_STATUS;
            res.data_word    = 16'd0;
            res.word_index   = 7'd0;
            res.frame_status = verdict.status;
            res.value_count  = verdict.value_count;
            res.crc_match    = crc_ok;
            res.exc_code     = verdict.exc_code;
        end else begin
            res.result_kind  = mrc_pkg::KIND_DATA;
            res.data_word    = {r_word_hi, i_rx_byte};
            res.word_index   = word_idx[6:0];
            res.frame_status = 3'd0;
            res.value_count  = 16'd0;
            res.crc_match    = 1'b0;
            res.exc_code     = 8'd0;
        end
    end

    always_comb begin
        n_crc       = r_crc;
        n_pos       = r_pos;
        n_dly0      = r_dly0;
        n_dly1      = r_dly1;
        n_seen_func = r_seen_func;
        n_seen_cnt  = r_seen_cnt;
        n_seen_wq   = r_seen_wq;
        n_word_hi   = r_word_hi;
        n_overrun   = r_overrun;
        if (in_acc) begin
            if (i_frame_end) begin
                n_crc       = mrc_pkg::CRC_INIT;
                n_pos       = 9'd0;
                n_dly0      = 8'd0;
                n_dly1      = 8'd0;
                n_seen_func = 8'd0;
                n_seen_cnt  = 8'd0;
                n_seen_wq   = 16'd0;
                n_word_hi   = 8'd0;
                n_overrun   = 1'b0;
            end else begin
                n_crc       = crc_fed;
                n_pos       = (r_pos == mrc_pkg::POS_CAP) ? r_pos : r_pos + 9'd1;
                n_dly0      = i_rx_byte;
                n_dly1      = r_dly0;
                n_seen_func = seen_func_now;
                n_seen_cnt  = seen_cnt_now;
                n_seen_wq   = seen_wq_now;
                n_word_hi   = hi_slot ? i_rx_byte : r_word_hi;
                n_overrun   = overrun_now;
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (in_acc && has_res) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_acc && has_res) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_function <= mrc_pkg::REQ_FUNCTION_RESET;
            r_req_quantity <= mrc_pkg::REQ_QUANTITY_RESET;
            r_crc          <= mrc_pkg::CRC_INIT;
            r_pos          <= 9'd0;
            r_dly0         <= 8'd0;
            r_dly1         <= 8'd0;
            r_seen_func    <= 8'd0;
            r_seen_cnt     <= 8'd0;
            r_seen_wq      <= 16'd0;
            r_word_hi      <= 8'd0;
            r_overrun      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == mrc_pkg::CFG_REQ_FUNCTION)) begin
                r_req_function <= i_cfg_data[7:0];
            end
            if (i_cfg_wr_en && (i_cfg_index == mrc_pkg::CFG_REQ_QUANTITY)) begin
                r_req_quantity <= i_cfg_data;
            end
            r_crc        <= n_crc;
            r_pos        <= n_pos;
            r_dly0       <= n_dly0;
            r_dly1       <= n_dly1;
            r_seen_func  <= n_seen_func;
            r_seen_cnt   <= n_seen_cnt;
            r_seen_wq    <= n_seen_wq;
            r_word_hi    <= n_word_hi;
            r_overrun    <= n_overrun;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out.result_kind;
    assign o_data_word    = r_out.data_word;
    assign o_word_index   = r_out.word_index;
    assign o_frame_status = r_out.frame_status;
    assign o_value_count  = r_out.value_count;
    assign o_crc_match    = r_out.crc_match;
    assign o_exc_code     = r_out.exc_code;

    assign frame_cleared     = (r_pos == 9'd0) && (r_crc == mrc_pkg::CRC_INIT) && !r_overrun;
    assign data_out          = r_out_valid && (r_out.result_kind == mrc_pkg::KIND_DATA);
    assign data_fields_clear = (r_out.frame_status == 3'd0) && (r_out.value_count == 16'd0) &&
                               !r_out.crc_match;

    `MRC_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `MRC_ASSERT_NEXT(a_frame_end_clears, i_clk, i_rst_n, in_acc && i_frame_end, frame_cleared)
    `MRC_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, in_acc && has_res, r_out_valid)
    `MRC_ASSERT_SAME(a_data_no_status, i_clk, i_rst_n, data_out, data_fields_clear)

endmodule

`default_nettype wire

>>> sim/frame_result_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker result monitor
// Watches the register port and both handshake channels of the response
// checker. A cycle-free predictor computes the data words and the frame
// status that each accepted byte causes. Accepted results are compared field
// by field with the oldest prediction. Failures are counted for the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_result_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_end,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic        o_result_kind,
    input  wire logic [15:0] o_data_word,
    input  wire logic [6:0]  o_word_index,
    input  wire logic [2:0]  o_frame_status,
    input  wire logic [15:0] o_value_count,
    input  wire logic        o_crc_match,
    input  wire logic [7:0]  o_exc_code,
    output int               o_fail_count,
    output int               o_pending_count
);
    import mrc_pkg::*;

    logic [7:0]  cfg_function;
    logic [15:0] cfg_quantity;

    logic [15:0] crc_acc;
    logic [8:0]  byte_pos;
    logic [7:0]  last_byte;
    logic [7:0]  older_byte;
    logic [7:0]  fn_seen;
    logic [7:0]  count_seen;
    logic [15:0] quantity_seen;
    logic [7:0]  word_high;
    bit          overrun;

    t_result due_results[$];
    int      mismatches = 0;

    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
        return c;
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf("kind %0d word %h index %0d status %0d count %0d crc %0d exc %h",
                         r.result_kind, r.data_word, r.word_index, r.frame_status,
                         r.value_count, r.crc_match, r.exc_code);
    endfunction

    task automatic clear_frame();
        crc_acc       = CRC_INIT;
        byte_pos      = '0;
        last_byte     = '0;
        older_byte    = '0;
        fn_seen       = '0;
        count_seen    = '0;
        quantity_seen = '0;
        word_high     = '0;
        overrun       = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fin);
        int unsigned   pos;
        int unsigned   idx;
        int unsigned   len;
        int unsigned   want_len;
        int unsigned   want;
        int unsigned   got;
        int unsigned   qn;
        bit            any_len;
        bit            is_read;
        logic [7:0]    prev;
        t_frame_status st;
        logic [15:0]   count;
        logic [7:0]    exc;
        logic          crc_ok;
        t_result       r;
        pos = byte_pos;
        prev = last_byte;
        qn = cfg_quantity;
        r = '0;
        if (byte_pos == MAX_FRAME_BYTES) overrun = 1'b1;
        if (pos >= 2) crc_acc = crc_fold(crc_acc, older_byte);
        case (pos)
            1: fn_seen = b;
            2: count_seen = b;
            4: quantity_seen[15:8] = b;
            5: quantity_seen[7:0] = b;
            default: ;
        endcase
        older_byte = last_byte;
        last_byte = b;
        is_read = (cfg_function == FN_READ_HOLDING) || (cfg_function == FN_READ_INPUT) ||
                  (cfg_function == FN_READ_WRITE_REGS);
        if (!fin) begin
            if (pos >= 3 && pos[0]) begin
                word_high = b;
            end else if (pos >= 4 && byte_pos != POS_CAP) begin
                idx = (pos - 4) >> 1;
                if (is_read && idx < qn && idx < 128) begin
                    r.result_kind = KIND_DATA;
                    r.data_word = {word_high, b};
                    r.word_index = idx[6:0];
                    due_results.push_back(r);
                end
            end
            if (byte_pos != POS_CAP) byte_pos = byte_pos + 9'd1;
        end else begin
            len = pos + 1;
            want_len = 8;
            any_len = 1'b0;
            case (cfg_function)
                FN_READ_COILS, FN_READ_DISCRETE: want_len = 5 + ((qn + 7) >> 3);
                FN_READ_HOLDING, FN_READ_INPUT, FN_READ_WRITE_REGS: want_len = 5 + 2 * qn;
                FN_READ_EXC_STATUS: want_len = 6;
                FN_REPORT_ID: any_len = 1'b1;
                default: want_len = 8;
            endcase
            st = FS_LENGTH;
            count = '0;
            exc = '0;
            crc_ok = 1'b0;
            if (!overrun && (any_len || len == want_len)) begin
                if (fn_seen != cfg_function) begin
                    st = FS_FUNCTION;
                end else begin
                    want = 1;
                    got = 1;
                    case (cfg_function)
                        FN_READ_COILS, FN_READ_DISCRETE: begin
                            want = (qn + 7) >> 3;
                            got = count_seen;
                        end
                        FN_READ_HOLDING, FN_READ_INPUT, FN_READ_WRITE_REGS: begin
                            want = qn;
                            got = count_seen >> 1;
                        end
                        FN_WRITE_COILS, FN_WRITE_REGS: begin
                            want = qn;
                            got = quantity_seen;
                        end
                        FN_REPORT_ID: begin
                            want = count_seen;
                            got = count_seen;
                        end
                        default: ;
                    endcase
                    if (want == got) begin
                        st = FS_OK;
                        count = got[15:0];
                    end else begin
                        st = FS_COUNT;
                    end
                end
            end else if (!overrun && len == 5 && fn_seen >= 8'h80 &&
                         (fn_seen - 8'h80) == cfg_function) begin
                st = FS_EXCEPTION;
                exc = count_seen;
            end
            if (len >= 2) crc_ok = ({prev, b} == {crc_acc[7:0], crc_acc[15:8]});
            r.result_kind = KIND_STATUS;
            r.frame_status = st;
            r.value_count = count;
            r.crc_match = crc_ok;
            r.exc_code = exc;
            due_results.push_back(r);
            clear_frame();
        end
    endtask

    task automatic check_result();
        t_result want;
        t_result got;
        got = '0;
        got.result_kind = o_result_kind;
        got.data_word = o_data_word;
        got.word_index = o_word_index;
        got.frame_status = o_frame_status;
        got.value_count = o_value_count;
        got.crc_match = o_crc_match;
        got.exc_code = o_exc_code;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: result with none due: %s", $time, describe(got));
        end else begin
            want = due_results.pop_front();
            if (want.result_kind !== got.result_kind || want.data_word !== got.data_word ||
                want.word_index !== got.word_index || want.frame_status !== got.frame_status ||
                want.value_count !== got.value_count || want.crc_match !== got.crc_match ||
                want.exc_code !== got.exc_code) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_function = REQ_FUNCTION_RESET;
            cfg_quantity = REQ_QUANTITY_RESET;
            clear_frame();
            due_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_REQ_FUNCTION) begin
                    cfg_function = i_cfg_data[7:0];
                end else begin
                    cfg_quantity = i_cfg_data;
                end
            end
            if (i_valid && !o_stall) predict_byte(i_rx_byte, i_frame_end);
            if (o_valid && !i_stall) check_result();
        end
        o_pending_count <= due_results.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Resets the block, sends a few directed frames under the reset settings, then
// runs phases that each set the request function and quantity and send frames:
// mostly well-formed responses with random content, and also frames with a bad
// CRC, function, count or length, exceptions, noise and overlong frames. Both
// sides pause at random. A separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import mrc_pkg::*;

    localparam int unsigned ITEM_TARGET = 1200;
    localparam int unsigned GAP_MAX = 13;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_CRC,
        SHAPE_BAD_FUNCTION,
        SHAPE_BAD_COUNT,
        SHAPE_BAD_LENGTH,
        SHAPE_EXCEPTION,
        SHAPE_NOISE,
        SHAPE_OVERLONG,
        SHAPE_SATURATE
    } t_frame_shape;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic        i_frame_end;
    logic        o_valid;
    logic        i_stall;
    logic        o_result_kind;
    logic [15:0] o_data_word;
    logic [6:0]  o_word_index;
    logic [2:0]  o_frame_status;
    logic [15:0] o_value_count;
    logic        o_crc_match;
    logic [7:0]  o_exc_code;

    int fail_count;
    int pending_count;

    int unsigned bytes_sent;
    bit          send_burst;
    bit          stall_quiet;
    int unsigned stall_left;
    int unsigned stall_draw;
    logic [7:0]  cur_function;
    logic [15:0] cur_quantity;
    logic [7:0]  frame_bytes[$];

    modbus_rtu_response_checker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_data_word    (o_data_word),
        .o_word_index   (o_word_index),
        .o_frame_status (o_frame_status),
        .o_value_count  (o_value_count),
        .o_crc_match    (o_crc_match),
        .o_exc_code     (o_exc_code)
    );

    frame_result_checker u_frame_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_kind   (o_result_kind),
        .o_data_word     (o_data_word),
        .o_word_index    (o_word_index),
        .o_frame_status  (o_frame_status),
        .o_value_count   (o_value_count),
        .o_crc_match     (o_crc_match),
        .o_exc_code      (o_exc_code),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            if ($urandom_range(0, 19) == 0) stall_quiet = !stall_quiet;
            stall_draw = stall_quiet ? 0 : $urandom_range(0, GAP_MAX);
            stall_left <= stall_draw;
            i_stall <= (stall_draw != 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= (stall_left > 1);
        end
    end

    function automatic logic [15:0] frame_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[n]) begin
            c = c ^ {8'h00, frame_bytes[n]};
            repeat (8) c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic int unsigned response_length(input logic [7:0] fn,
                                                    input logic [15:0] qty);
        int unsigned qn;
        qn = qty;
        case (fn)
            FN_READ_COILS, FN_READ_DISCRETE: return 5 + ((qn + 7) >> 3);
            FN_READ_HOLDING, FN_READ_INPUT, FN_READ_WRITE_REGS: return 5 + 2 * qn;
            FN_READ_EXC_STATUS: return 6;
            FN_REPORT_ID: return $urandom_range(5, 12);
            default: return 8;
        endcase
    endfunction

    function automatic t_frame_shape draw_shape();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return SHAPE_GOOD;
        if (r < 62) return SHAPE_BAD_CRC;
        if (r < 69) return SHAPE_BAD_FUNCTION;
        if (r < 76) return SHAPE_BAD_COUNT;
        if (r < 84) return SHAPE_BAD_LENGTH;
        if (r < 92) return SHAPE_EXCEPTION;
        if (r < 99) return SHAPE_NOISE;
        return SHAPE_OVERLONG;
    endfunction

    task automatic build_frame(input t_frame_shape shape);
        int unsigned len;
        int unsigned extra;
        int unsigned qn;
        logic [15:0] crc;
        qn = cur_quantity;
        frame_bytes.delete();
        case (shape)
            SHAPE_NOISE: len = $urandom_range(1, 12);
            SHAPE_EXCEPTION: len = 3;
            SHAPE_OVERLONG: len = $urandom_range(255, 268);
            SHAPE_SATURATE: len = 513;
            default: begin
                len = response_length(cur_function, cur_quantity) - 2;
                if (len > 298) len = $urandom_range(4, 40);
            end
        endcase
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
        if (shape != SHAPE_NOISE) begin
            frame_bytes[1] = (shape == SHAPE_EXCEPTION) ? cur_function + 8'h80 : cur_function;
            if (shape != SHAPE_EXCEPTION && shape != SHAPE_OVERLONG && shape != SHAPE_SATURATE)
            begin
                case (cur_function)
                    FN_READ_COILS, FN_READ_DISCRETE: frame_bytes[2] = 8'((qn + 7) >> 3);
                    FN_READ_HOLDING, FN_READ_INPUT, FN_READ_WRITE_REGS:
                        frame_bytes[2] = 8'(qn * 2);
                    FN_WRITE_COILS, FN_WRITE_REGS: begin
                        frame_bytes[4] = cur_quantity[15:8];
                        frame_bytes[5] = cur_quantity[7:0];
                    end
                    default: ;
                endcase
                case (shape)
                    SHAPE_BAD_FUNCTION:
                        frame_bytes[1] = cur_function ^ 8'($urandom_range(1, 255));
                    SHAPE_BAD_COUNT: begin
                        if (cur_function == FN_WRITE_COILS || cur_function == FN_WRITE_REGS) begin
                            extra = 4 + $urandom_range(0, 1);
                        end else begin
                            extra = 2;
                        end
                        frame_bytes[extra] = frame_bytes[extra] ^ 8'($urandom_range(1, 255));
                    end
                    SHAPE_BAD_LENGTH: begin
                        extra = $urandom_range(1, 3);
                        if ($urandom_range(0, 1) == 0 && frame_bytes.size() > 3 + extra) begin
                            repeat (extra) void'(frame_bytes.pop_back());
                        end else begin
                            repeat (extra) frame_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                    end
                    default: ;
                endcase
            end
            crc = frame_crc();
            if (shape == SHAPE_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
        end
    endtask

    task automatic send_frame();
        int unsigned gap;
        send_burst = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < frame_bytes.size(); n++) begin
            gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_rx_byte <= frame_bytes[n];
            i_frame_end <= (n == frame_bytes.size() - 1);
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] fn, input logic [15:0] qty);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_REQ_FUNCTION;
        i_cfg_data <= {8'($urandom_range(0, 255)), fn};
        @(posedge i_clk);
        i_cfg_index <= CFG_REQ_QUANTITY;
        i_cfg_data <= qty;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        cur_function = fn;
        cur_quantity = qty;
    endtask

    task automatic send_directed(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input int unsigned len);
        frame_bytes.delete();
        frame_bytes.push_back(b0);
        if (len >= 2) frame_bytes.push_back(b1);
        if (len >= 3) begin
            frame_bytes.push_back(b2);
            build_crc_tail();
        end
        send_frame();
    endtask

    task automatic build_crc_tail();
        logic [15:0] crc;
        crc = frame_crc();
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    task automatic run_phase(input int unsigned phase);
        logic [7:0]  fn;
        logic [15:0] qty;
        int unsigned frames;
        case (phase)
            0: begin fn = FN_READ_COILS; qty = 16'd0; end
            1: begin fn = FN_READ_DISCRETE; qty = 16'd21; end
            2: begin fn = FN_READ_HOLDING; qty = 16'hFFFF; end
            3: begin fn = FN_READ_INPUT; qty = 16'd4; end
            4: begin fn = FN_READ_EXC_STATUS; qty = 16'd0; end
            5: begin fn = FN_WRITE_COILS; qty = 16'hFFFF; end
            6: begin fn = FN_WRITE_REGS; qty = 16'd10; end
            7: begin fn = FN_REPORT_ID; qty = 16'd300; end
            8: begin fn = FN_READ_WRITE_REGS; qty = 16'd2; end
            9: begin fn = 8'h00; qty = 16'd0; end
            10: begin fn = 8'hFF; qty = 16'hFFFF; end
            11: begin fn = FN_READ_HOLDING; qty = 16'd1; end
            default: begin
                case ($urandom_range(0, 9))
                    0: fn = FN_READ_COILS;
                    1: fn = FN_READ_DISCRETE;
                    2: fn = FN_READ_HOLDING;
                    3: fn = FN_READ_INPUT;
                    4: fn = FN_READ_EXC_STATUS;
                    5: fn = FN_WRITE_COILS;
                    6: fn = FN_WRITE_REGS;
                    7: fn = FN_REPORT_ID;
                    8: fn = FN_READ_WRITE_REGS;
                    default: fn = 8'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    qty = 16'($urandom_range(0, 65535));
                end else begin
                    qty = 16'($urandom_range(0, 12));
                end
            end
        endcase
        configure(fn, qty);
        frames = $urandom_range(4, 10);
        repeat (frames) begin
            build_frame(draw_shape());
            send_frame();
        end
        if (phase == 2) begin
            build_frame(SHAPE_SATURATE);
            send_frame();
        end
        settle();
    endtask

    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int unsigned phase;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_REQ_FUNCTION;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_rx_byte <= '0;
        i_frame_end <= 1'b0;
        i_stall <= 1'b0;
        stall_left = 0;
        stall_quiet = 1'b0;
        bytes_sent = 0;
        cur_function = REQ_FUNCTION_RESET;
        cur_quantity = REQ_QUANTITY_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: read holding registers, quantity zero.
        send_directed(8'hFF, 8'h00, 8'h00, 1);
        send_directed(8'hFF, 8'hFF, 8'h00, 2);
        send_directed(8'h01, FN_READ_HOLDING, 8'h00, 3);
        send_directed(8'h01, FN_READ_HOLDING + 8'h80, 8'h02, 3);
        send_directed(8'h00, FN_READ_INPUT, 8'h00, 3);
        send_directed(8'h11, FN_READ_HOLDING, 8'h02, 3);
        settle();

        for (phase = 0; phase < 12 || bytes_sent < ITEM_TARGET; phase++) run_phase(phase);

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
